>>> hdl/heat_plate_relaxation_top_assert.svh
// Assertion macros shared by the heat plate relaxation RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef HEAT_PLATE_RELAXATION_TOP_ASSERT_SVH
`define HEAT_PLATE_RELAXATION_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define HPR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heat plate check failed");

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define HPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heat plate check failed");

`endif

>>> hdl/hpr_pkg.sv
`default_nettype none

package hpr_pkg;

    localparam int MAX_SIDE = 32;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    localparam int CNT_W    = $clog2(MAX_SIDE + 1);
    localparam int ADDR_W   = 2 * SIDE_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int TEMP_W   = 16;
    localparam int MIN_SIDE = 3;
    localparam int ONE_Q88  = 256;

    // configuration register indexes
    localparam logic [2:0] CFG_LEFT   = 3'd0;
    localparam logic [2:0] CFG_RIGHT  = 3'd1;
    localparam logic [2:0] CFG_TOP    = 3'd2;
    localparam logic [2:0] CFG_BOTTOM = 3'd3;
    localparam logic [2:0] CFG_SIDE   = 3'd4;
    localparam logic [2:0] CFG_PROBER = 3'd5;
    localparam logic [2:0] CFG_PROBEC = 3'd6;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_SWEEP = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SW_TOP,
        S_SW_A,
        S_SW_B,
        S_SW_FLUSH,
        S_PROBE,
        S_RESULT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT_WR,
        OP_SW_TOP,
        OP_SW_A,
        OP_SW_B,
        OP_SW_FLUSH,
        OP_PROBE
    } op_t;

    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_ZERO,
        CNT_ONE,
        CNT_ROW,
        CNT_COL_INIT,
        CNT_COL_SWEEP
    } cnt_t;

    typedef struct packed {
        op_t  op;
        cnt_t cnt;
        logic req_load;
        logic res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic r_edge;      // row counter at n-1
        logic c_edge;      // column counter at n-1
        logic r_inner_end; // row counter at n-2
        logic c_inner_end; // column counter at n-2
    } dp_sts_t;

endpackage

`default_nettype wire

>>> hdl/hpr_dp.sv
`default_nettype none

module hpr_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hpr_pkg::dp_cmd_t              cmd,
    output hpr_pkg::dp_sts_t                   sts,
    input  wire logic [1:0]                    mode,
    input  wire logic [4:0]                    row,
    input  wire logic [4:0]                    col,
    input  wire logic [hpr_pkg::CNT_W-1:0]     n,
    input  wire logic signed [15:0]            left_temp,
    input  wire logic signed [15:0]            right_temp,
    input  wire logic signed [15:0]            top_temp,
    input  wire logic signed [15:0]            bottom_temp,
    input  wire logic [4:0]                    probe_row,
    input  wire logic [4:0]                    probe_col,
    output logic signed [15:0]                 cell_value,
    output logic                               probe_reached
);

    localparam int SW = hpr_pkg::SIDE_W;
    localparam int CW = hpr_pkg::CNT_W;
    localparam int AW = hpr_pkg::ADDR_W;

    function automatic logic [AW-1:0] cell_addr(input logic [SW-1:0] r, input logic [SW-1:0] c);
        return {r, c};
    endfunction

    logic signed [15:0] mem [hpr_pkg::DEPTH];

    logic [SW-1:0]      r_reg, r_next;
    logic [SW-1:0]      c_reg, c_next;
    logic [1:0]         mode_q_reg;
    logic [4:0]         req_row_reg;
    logic [4:0]         req_col_reg;
    logic signed [15:0] up_reg;
    logic signed [15:0] down_reg;
    logic signed [15:0] left_reg;
    logic [AW-1:0]      wr_addr_reg;
    logic signed [15:0] rd0_reg;
    logic signed [15:0] rd1_reg;
    logic signed [15:0] cell_value_reg;
    logic               probe_reached_reg;

    logic [CW-1:0]      r_ext, c_ext;
    logic signed [17:0] sum;
    logic signed [15:0] relax;
    logic signed [15:0] init_val;
    logic               rd_en0, rd_en1, wr_en;
    logic [AW-1:0]      rd_addr0, rd_addr1, wr_addr;
    logic signed [15:0] wr_data;
    logic               probe_in, req_in;
    logic signed [15:0] probe_val;
    logic signed [16:0] threshold;

    assign r_ext = CW'(r_reg);
    assign c_ext = CW'(c_reg);

    always_comb
    begin
        sts.r_edge      = (r_ext + CW'(1) == n);
        sts.c_edge      = (c_ext + CW'(1) == n);
        sts.r_inner_end = (r_ext + CW'(2) == n);
        sts.c_inner_end = (c_ext + CW'(2) == n);
    end

    // floor of the neighbor mean: arithmetic shift of the 18-bit sum
    assign sum   = 18'(up_reg) + 18'(down_reg) + 18'(left_reg) + 18'(rd0_reg);
    assign relax = sum[17:2];

    // column values win at the corners
    always_comb
    begin
        if (c_reg == '0)
            init_val = left_temp;
        else if (sts.c_edge)
            init_val = right_temp;
        else if (r_reg == '0)
            init_val = top_temp;
        else if (sts.r_edge)
            init_val = bottom_temp;
        else
            init_val = '0;
    end

    always_comb
    begin
        rd_en0   = 1'b0;
        rd_en1   = 1'b0;
        wr_en    = 1'b0;
        rd_addr0 = cell_addr(r_reg + SW'(1), c_reg);
        rd_addr1 = cell_addr(r_reg, c_reg - SW'(1));
        wr_addr  = wr_addr_reg;
        wr_data  = relax;
        case (cmd.op)
            hpr_pkg::OP_INIT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = cell_addr(r_reg, c_reg);
                wr_data = init_val;
            end
            hpr_pkg::OP_SW_TOP:
            begin
                rd_en0   = 1'b1;
                rd_addr0 = cell_addr('0, c_reg);
                wr_en    = (c_reg != SW'(1));
            end
            hpr_pkg::OP_SW_A:
            begin
                rd_en0 = 1'b1;
                rd_en1 = 1'b1;
                wr_en  = (r_reg != SW'(1));
            end
            hpr_pkg::OP_SW_B:
            begin
                rd_en0   = 1'b1;
                rd_addr0 = cell_addr(r_reg, c_reg + SW'(1));
            end
            hpr_pkg::OP_SW_FLUSH:
            begin
                wr_en = 1'b1;
            end
            hpr_pkg::OP_PROBE:
            begin
                rd_en0   = 1'b1;
                rd_en1   = 1'b1;
                rd_addr0 = cell_addr(SW'(probe_row), SW'(probe_col));
                rd_addr1 = cell_addr(SW'(req_row_reg), SW'(req_col_reg));
            end
            default:
            begin
                rd_en0 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en0)
            rd0_reg <= mem[rd_addr0];
        if (rd_en1)
            rd1_reg <= mem[rd_addr1];
    end

    // advance the scan counters
    always_comb
    begin
        r_next = r_reg;
        c_next = c_reg;
        case (cmd.cnt)
            hpr_pkg::CNT_ZERO:
            begin
                r_next = '0;
                c_next = '0;
            end
            hpr_pkg::CNT_ONE:
            begin
                r_next = SW'(1);
                c_next = SW'(1);
            end
            hpr_pkg::CNT_ROW:
            begin
                r_next = r_reg + SW'(1);
            end
            hpr_pkg::CNT_COL_INIT:
            begin
                r_next = '0;
                c_next = c_reg + SW'(1);
            end
            hpr_pkg::CNT_COL_SWEEP:
            begin
                r_next = SW'(1);
                c_next = c_reg + SW'(1);
            end
            default:
            begin
                r_next = r_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0;
            c_reg <= '0;
        end
        else
        begin
            r_reg <= r_next;
            c_reg <= c_next;
        end
    end

    // stencil operand holding
    always_ff @(posedge clk)
    begin
        if (cmd.op == hpr_pkg::OP_SW_A)
            up_reg <= (r_reg == SW'(1)) ? rd0_reg : relax;
        if (cmd.op == hpr_pkg::OP_SW_B)
        begin
            down_reg    <= rd0_reg;
            left_reg    <= rd1_reg;
            wr_addr_reg <= cell_addr(r_reg, c_reg);
        end
        if (cmd.req_load)
        begin
            mode_q_reg  <= mode;
            req_row_reg <= row;
            req_col_reg <= col;
        end
    end

    // result formation
    assign probe_in  = (int'(probe_row) < int'(n)) && (int'(probe_col) < int'(n));
    assign req_in    = (int'(req_row_reg) < int'(n)) && (int'(req_col_reg) < int'(n));
    assign probe_val = probe_in ? rd0_reg : '0;
    assign threshold = 17'(left_temp) - 17'(hpr_pkg::ONE_Q88);

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            cell_value_reg    <= (mode_q_reg == hpr_pkg::MODE_READ && req_in) ? rd1_reg : '0;
            probe_reached_reg <= (17'(probe_val) >= threshold);
        end
    end

    assign cell_value    = cell_value_reg;
    assign probe_reached = probe_reached_reg;

endmodule

`default_nettype wire

>>> hdl/hpr_ctrl.sv
`default_nettype none

`include "heat_plate_relaxation_top_assert.svh"

module hpr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       mode,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire hpr_pkg::dp_sts_t sts,
    output hpr_pkg::dp_cmd_t      cmd
);

    hpr_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpr_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = hpr_pkg::OP_NONE;
        cmd.cnt        = hpr_pkg::CNT_HOLD;
        cmd.req_load   = 1'b0;
        cmd.res_load   = 1'b0;
        case (state_reg)
            hpr_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    if (mode == hpr_pkg::MODE_INIT)
                    begin
                        cmd.cnt    = hpr_pkg::CNT_ZERO;
                        state_next = hpr_pkg::S_INIT;
                    end
                    else if (mode == hpr_pkg::MODE_SWEEP)
                    begin
                        cmd.cnt    = hpr_pkg::CNT_ONE;
                        state_next = hpr_pkg::S_SW_TOP;
                    end
                    else
                    begin
                        state_next = hpr_pkg::S_PROBE;
                    end
                end
            end
            hpr_pkg::S_INIT:
            begin
                cmd.op = hpr_pkg::OP_INIT_WR;
                if (!sts.r_edge)
                    cmd.cnt = hpr_pkg::CNT_ROW;
                else if (!sts.c_edge)
                    cmd.cnt = hpr_pkg::CNT_COL_INIT;
                else
                    state_next = hpr_pkg::S_PROBE;
            end
            hpr_pkg::S_SW_TOP:
            begin
                cmd.op     = hpr_pkg::OP_SW_TOP;
                state_next = hpr_pkg::S_SW_A;
            end
            hpr_pkg::S_SW_A:
            begin
                cmd.op     = hpr_pkg::OP_SW_A;
                state_next = hpr_pkg::S_SW_B;
            end
            hpr_pkg::S_SW_B:
            begin
                cmd.op = hpr_pkg::OP_SW_B;
                if (!sts.r_inner_end)
                begin
                    cmd.cnt    = hpr_pkg::CNT_ROW;
                    state_next = hpr_pkg::S_SW_A;
                end
                else if (!sts.c_inner_end)
                begin
                    cmd.cnt    = hpr_pkg::CNT_COL_SWEEP;
                    state_next = hpr_pkg::S_SW_TOP;
                end
                else
                begin
                    state_next = hpr_pkg::S_SW_FLUSH;
                end
            end
            hpr_pkg::S_SW_FLUSH:
            begin
                cmd.op     = hpr_pkg::OP_SW_FLUSH;
                state_next = hpr_pkg::S_PROBE;
            end
            hpr_pkg::S_PROBE:
            begin
                cmd.op     = hpr_pkg::OP_PROBE;
                state_next = hpr_pkg::S_RESULT;
            end
            hpr_pkg::S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = hpr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hpr_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    `HPR_ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ready, out_valid_reg)
    `HPR_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_reg != hpr_pkg::S_IDLE)
    `HPR_ASSERT_NEXT(a_sweep_pair, state_reg == hpr_pkg::S_SW_A, state_reg == hpr_pkg::S_SW_B)
    `HPR_ASSERT_IMP(a_load_free, cmd.res_load, !out_valid_reg || out_ready)

endmodule

`default_nettype wire

>>> hdl/heat_plate_relaxation_top.sv
`default_nettype none

// Channel   Handshake             Payload
// in        in_valid / in_ready   mode, row, col
// out       out_valid / out_ready cell_value, probe_reached
// cfg       cfg_we (no wait)      cfg_addr, cfg_wdata
//
// Per transaction, n = side in use: initialize writes all n*n cells, sweep
// relaxes the interior column by column, and every mode ends with a probe
// and a result step. Two plate read ports set the sweep pace: each interior
// cell needs three neighbor reads, so it takes an S_SW_A and an S_SW_B step.
// Reset clears the controller, scan counters and configuration, not the plate.
// A waiting result does not block in; the next result holds until out drains.

module heat_plate_relaxation_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         mode,
    input  wire logic [4:0]         row,
    input  wire logic [4:0]         col,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      cell_value,
    output logic                    probe_reached,
    // configuration write port
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [15:0]        cfg_wdata
);

    localparam int CW = hpr_pkg::CNT_W;

    logic signed [15:0] left_temp_reg;
    logic signed [15:0] right_temp_reg;
    logic signed [15:0] top_temp_reg;
    logic signed [15:0] bottom_temp_reg;
    logic [5:0]         side_cells_reg;
    logic [4:0]         probe_row_reg;
    logic [4:0]         probe_col_reg;

    logic [CW-1:0]      n;
    hpr_pkg::dp_cmd_t   cmd;
    hpr_pkg::dp_sts_t   sts;

    // Configuration register file; write it only while the block is idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_temp_reg   <= '0;
            right_temp_reg  <= '0;
            top_temp_reg    <= '0;
            bottom_temp_reg <= '0;
            side_cells_reg  <= 6'd16;
            probe_row_reg   <= 5'd5;
            probe_col_reg   <= 5'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                hpr_pkg::CFG_LEFT:   left_temp_reg   <= cfg_wdata;
                hpr_pkg::CFG_RIGHT:  right_temp_reg  <= cfg_wdata;
                hpr_pkg::CFG_TOP:    top_temp_reg    <= cfg_wdata;
                hpr_pkg::CFG_BOTTOM: bottom_temp_reg <= cfg_wdata;
                hpr_pkg::CFG_SIDE:   side_cells_reg  <= cfg_wdata[5:0];
                hpr_pkg::CFG_PROBER: probe_row_reg   <= cfg_wdata[4:0];
                hpr_pkg::CFG_PROBEC: probe_col_reg   <= cfg_wdata[4:0];
                default:             side_cells_reg  <= side_cells_reg;
            endcase
        end
    end

    // Clamp the requested side to the range the plate memory supports.
    always_comb
    begin
        if (int'(side_cells_reg) < hpr_pkg::MIN_SIDE)
            n = CW'(hpr_pkg::MIN_SIDE);
        else if (int'(side_cells_reg) > hpr_pkg::MAX_SIDE)
            n = CW'(hpr_pkg::MAX_SIDE);
        else
            n = CW'(side_cells_reg);
    end

    // Sequencer: steps through initialize, sweep and probe phases.
    hpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Plate memory, stencil adder, scan counters and result register.
    hpr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .mode          (mode),
        .row           (row),
        .col           (col),
        .n             (n),
        .left_temp     (left_temp_reg),
        .right_temp    (right_temp_reg),
        .top_temp      (top_temp_reg),
        .bottom_temp   (bottom_temp_reg),
        .probe_row     (probe_row_reg),
        .probe_col     (probe_col_reg),
        .cell_value    (cell_value),
        .probe_reached (probe_reached)
    );

endmodule

`default_nettype wire

>>> test/hpr_plate_checker.sv
`timescale 1ns / 1ps

module hpr_plate_checker
    import hpr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [1:0]         mode,
    input  wire logic [4:0]         row,
    input  wire logic [4:0]         col,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [15:0] cell_value,
    input  wire logic               probe_reached,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [15:0]        cfg_wdata,
    output int                      mismatches,
    output int                      backlog
);

    typedef struct packed {
        logic signed [15:0] value_q88;
        logic               probe;
    } plate_answer_t;

    logic signed [15:0] plate_q88 [DEPTH];
    logic signed [15:0] left_t, right_t, top_t, bottom_t;
    logic [5:0]         side_reg;
    logic [4:0]         probe_r, probe_c;
    plate_answer_t      answers_q [$];

    function automatic int side_n();
        int n;
        n = side_reg;
        if (n < MIN_SIDE) n = MIN_SIDE;
        if (n > MAX_SIDE) n = MAX_SIDE;
        return n;
    endfunction

    // cells beyond the plate in use read as zero
    function automatic int cell_at(int r, int c);
        int n;
        n = side_n();
        if (r >= n || c >= n) return 0;
        return plate_q88[r * MAX_SIDE + c];
    endfunction

    function automatic void fill_plate();
        int n, r, c;
        n = side_n();
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                plate_q88[r * MAX_SIDE + c] = '0;
        for (c = 0; c < n; c++)
        begin
            plate_q88[c] = top_t;
            plate_q88[(n - 1) * MAX_SIDE + c] = bottom_t;
        end
        // columns last, so the corners hold the column values
        for (r = 0; r < n; r++)
        begin
            plate_q88[r * MAX_SIDE] = left_t;
            plate_q88[r * MAX_SIDE + n - 1] = right_t;
        end
    endfunction

    // in-place sweep, column major; the arithmetic shift floors the quarter
    function automatic void relax_sweep();
        int n, r, c, s, q;
        n = side_n();
        for (c = 1; c + 1 < n; c++)
            for (r = 1; r + 1 < n; r++)
            begin
                s = cell_at(r + 1, c) + cell_at(r - 1, c)
                  + cell_at(r, c + 1) + cell_at(r, c - 1);
                q = s >>> 2;
                plate_q88[r * MAX_SIDE + c] = q[15:0];
            end
    endfunction

    function automatic plate_answer_t relax_step(mode_t m, logic [4:0] r, logic [4:0] c);
        plate_answer_t a;
        a.value_q88 = '0;
        case (m)
            MODE_INIT:  fill_plate();
            MODE_SWEEP: relax_sweep();
            MODE_READ:  a.value_q88 = 16'(cell_at(int'(r), int'(c)));
            default:    ;
        endcase
        a.probe = (cell_at(int'(probe_r), int'(probe_c)) >= int'(left_t) - ONE_Q88);
        return a;
    endfunction

    always @(posedge clk)
    begin
        plate_answer_t got, want;
        if (!rst_n)
        begin
            left_t   = '0;
            right_t  = '0;
            top_t    = '0;
            bottom_t = '0;
            side_reg = 6'd16;
            probe_r  = 5'd5;
            probe_c  = 5'd5;
            answers_q.delete();
            mismatches = 0;
        end
        else
        begin
            // compare before taking a new transaction: no result can share
            // the edge with its own request
            if (out_valid && out_ready)
            begin
                got.value_q88 = cell_value;
                got.probe     = probe_reached;
                if (answers_q.size() == 0)
                begin
                    $error("unexpected result: cell_value %0d probe_reached %0b",
                           got.value_q88, got.probe);
                    mismatches++;
                end
                else
                begin
                    want = answers_q.pop_front();
                    if (got.value_q88 !== want.value_q88)
                    begin
                        $error("cell_value: expected %0d, actual %0d",
                               want.value_q88, got.value_q88);
                        mismatches++;
                    end
                    if (got.probe !== want.probe)
                    begin
                        $error("probe_reached: expected %0b, actual %0b",
                               want.probe, got.probe);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_LEFT:   left_t   = cfg_wdata;
                    CFG_RIGHT:  right_t  = cfg_wdata;
                    CFG_TOP:    top_t    = cfg_wdata;
                    CFG_BOTTOM: bottom_t = cfg_wdata;
                    CFG_SIDE:   side_reg = cfg_wdata[5:0];
                    CFG_PROBER: probe_r  = cfg_wdata[4:0];
                    CFG_PROBEC: probe_c  = cfg_wdata[4:0];
                    default:    ;
                endcase
            end
            if (in_valid && in_ready)
                answers_q.push_back(relax_step(mode_t'(mode), row, col));
        end
        backlog = answers_q.size();
    end

endmodule

>>> test/tb_heat_plate_relaxation_top.sv
`timescale 1ns / 1ps

module tb_heat_plate_relaxation_top;
    import hpr_pkg::*;

    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 40;
    // a full 32 cell sweep runs with no transaction on either channel,
    // so the limit must cover it
    localparam int STALL_LIMIT  = 12000;
    // after the final drain, wait for any stray results
    localparam int DRAIN_CYCLES = 16;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         mode = '0;
    logic [4:0]         row = '0;
    logic [4:0]         col = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] cell_value;
    logic               probe_reached;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_addr = '0;
    logic [15:0]        cfg_wdata = '0;

    int mismatches;
    int backlog;
    // when set, neither side inserts idle cycles
    bit steady = 1'b0;
    int ready_hold = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    heat_plate_relaxation_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .row           (row),
        .col           (col),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_value    (cell_value),
        .probe_reached (probe_reached),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    hpr_plate_checker plate_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .row           (row),
        .col           (col),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_value    (cell_value),
        .probe_reached (probe_reached),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .backlog       (backlog)
    );

    // Result side back-pressure: drop ready in random bursts set by ready_hold.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready  <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 4) == 0)
        begin
            out_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 2);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_heat_plate_relaxation_top NOT OK");
            $finish;
        end
    end

    // Offer one transaction and hold it until accepted. Valid stays high on
    // return so back-to-back transactions follow without a gap.
    task automatic send_item(input mode_t m, input logic [4:0] r, input logic [4:0] c);
        int gap;
        gap = (steady || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        row      <= r;
        col      <= c;
        do @(posedge clk); while (in_ready !== 1'b1);
    endtask

    // Hold the sender until every outstanding result has come back. Sample
    // the checker's count on the falling edge, away from its update.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (backlog != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Registers change only with the block idle: drain first, settle, then
    // write all seven.
    task automatic load_config(input logic [15:0] lt, input logic [15:0] rt,
                               input logic [15:0] tt, input logic [15:0] bt,
                               input logic [5:0] side, input logic [4:0] pr,
                               input logic [4:0] pc);
        drain_results();
        repeat (4) @(posedge clk);
        write_reg(CFG_LEFT, lt);
        write_reg(CFG_RIGHT, rt);
        write_reg(CFG_TOP, tt);
        write_reg(CFG_BOTTOM, bt);
        write_reg(CFG_SIDE, 16'(side));
        write_reg(CFG_PROBER, 16'(pr));
        write_reg(CFG_PROBEC, 16'(pc));
        cfg_we <= 1'b0;
    endtask

    // Edge temperature: extremes, something near zero, or anything.
    function automatic logic [15:0] pick_temp();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(0, 2048));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int          ph, k, n, sweeps, pick;
        bit          big;
        logic [5:0]  side;
        logic [4:0]  pr, pc, r, c;
        mode_t       m;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset configuration, a 16 cell plate at zero. The first
        // transaction must initialize, since the plate memory is garbage.
        send_item(MODE_INIT, 5'd0, 5'd0);
        send_item(MODE_READ, 5'd0, 5'd0);
        send_item(MODE_READ, 5'd15, 5'd15);
        send_item(MODE_READ, 5'd16, 5'd3);      // outside the plate in use
        send_item(MODE_SWEEP, 5'd0, 5'd0);
        send_item(MODE_READ, 5'd5, 5'd5);
        send_item(MODE_NOP, 5'd31, 5'd31);

        // Opposite extremes on a side below the minimum: the plate clamps
        // to 3, the corners take the column values and the single interior
        // cell floors a negative sum.
        load_config(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 6'd0, 5'd1, 5'd1);
        send_item(MODE_INIT, 5'd31, 5'd31);
        send_item(MODE_READ, 5'd0, 5'd0);
        send_item(MODE_READ, 5'd0, 5'd1);
        send_item(MODE_READ, 5'd2, 5'd1);
        send_item(MODE_READ, 5'd2, 5'd2);
        send_item(MODE_SWEEP, 5'd0, 5'd0);
        send_item(MODE_READ, 5'd1, 5'd1);
        send_item(MODE_READ, 5'd3, 5'd0);
        send_item(MODE_NOP, 5'd0, 5'd0);

        // Largest sum of four cells; the probe sits outside the plate.
        load_config(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 6'd4, 5'd31, 5'd31);
        send_item(MODE_INIT, 5'd0, 5'd0);
        send_item(MODE_SWEEP, 5'd0, 5'd0);
        send_item(MODE_READ, 5'd1, 5'd2);
        send_item(MODE_READ, 5'd31, 5'd31);
        send_item(MODE_NOP, 5'd0, 5'd0);

        // Smallest sum; the probe threshold drops below the 16 bit range.
        load_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, 6'd5, 5'd2, 5'd2);
        send_item(MODE_INIT, 5'd0, 5'd0);
        send_item(MODE_SWEEP, 5'd0, 5'd0);
        send_item(MODE_READ, 5'd2, 5'd2);

        // Random phases: each starts from a fresh configuration and an
        // initialize, then mixes sweeps, reads, no-ops and more initializes. Most plates are
        // small; two phases use the full size with few sweeps.
        for (ph = 0; ph < PHASES; ph++)
        begin
            big = (ph == 3 || ph == 9);
            if (ph == 3)
                side = 6'd32;
            else if (ph == 9)
                side = 6'd63;
            else if (ph == 6)
                side = 6'(16 + $urandom_range(0, 3));
            else if (ph % 5 == 1)
                side = 6'($urandom_range(0, 2));
            else
                side = 6'($urandom_range(3, 12));
            n = (side < MIN_SIDE) ? MIN_SIDE : (side > MAX_SIDE) ? MAX_SIDE : int'(side);
            pr = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, n - 1));
            pc = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, n - 1));
            load_config(pick_temp(), pick_temp(), pick_temp(), pick_temp(), side, pr, pc);

            // calm stretches now and then, and calm throughout toward the end
            steady = (ph % 4 == 1) || (ph >= PHASES - 2);

            send_item(MODE_INIT, 5'($urandom), 5'($urandom));
            sweeps = 0;
            for (k = 1; k < PHASE_ITEMS; k++)
            begin
                // hold the sender until the block has caught up
                if (k == PHASE_ITEMS / 2 && ph % 4 == 2)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    m = MODE_INIT;
                else if (pick < 12)
                    m = MODE_NOP;
                else if (pick < 45 && (!big || sweeps < 2))
                    m = MODE_SWEEP;
                else
                    m = MODE_READ;
                if (m == MODE_SWEEP)
                    sweeps++;
                r = ($urandom_range(0, 6) == 0) ? 5'($urandom) : 5'($urandom_range(0, n - 1));
                c = ($urandom_range(0, 6) == 0) ? 5'($urandom) : 5'($urandom_range(0, n - 1));
                send_item(m, r, c);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && backlog == 0)
            $display("tb_heat_plate_relaxation_top OK");
        else
            $display("tb_heat_plate_relaxation_top NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/hpr_pkg.sv
hdl/hpr_dp.sv
hdl/hpr_ctrl.sv
hdl/heat_plate_relaxation_top.sv
test/hpr_plate_checker.sv
test/tb_heat_plate_relaxation_top.sv
